[rtl/matrix4_multiply_engine_top_defines.svh]
// Assertion macros for the 4x4 matrix multiply engine.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef MATRIX4_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX4_MULTIPLY_ENGINE_TOP_DEFINES_SVH

// Property checked on every edge outside reset.
`define MME_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked only on edges where a guard holds.
`define MME_ASSERT_IF(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> prop) \
      else $error(msg);

`endif

[rtl/mme_pkg.sv]
// Shared types and constants for the 4x4 matrix multiply engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package mme_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIM       = 4;
   localparam int N_ELEM    = DIM * DIM;
   localparam int K_BITS    = $clog2(DIM);
   localparam int IDX_BITS  = $clog2(N_ELEM);
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;

   localparam logic signed [WORD_BITS-1:0] UNIT_VALUE = WORD_BITS'(1) << FRAC_BITS;
   localparam logic signed [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [WORD_BITS-1:0] WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic TARGET_LEFT  = 1'b0;
   localparam logic TARGET_RIGHT = 1'b1;

   typedef struct packed {
      logic                        target_matrix;
      logic [IDX_BITS-1:0]         element_index;
      logic signed [WORD_BITS-1:0] element_value;
      logic                        start_product;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] product_value;
      logic [IDX_BITS-1:0]         product_index;
      logic                        saturated;
      logic                        last_of_product;
   } rsp_item_type;

   // Right-matrix operand travelling down the cell chain
   typedef struct packed {
      logic                        valid;
      logic [K_BITS-1:0]           k;
      logic signed [WORD_BITS-1:0] value;
   } cell_feed_type;

   // Write of one left-matrix element into a cell's row
   typedef struct packed {
      logic                        en;
      logic [K_BITS-1:0]           k;
      logic signed [WORD_BITS-1:0] value;
   } left_write_type;

endpackage

`default_nettype wire

[rtl/matrix4_multiply_engine_top.sv]
// 4x4 matrix multiply engine, column-major, signed Q16.16, built on a chain of four MAC cells.
// Item without start_product: stored, ready again at once. Item with start_product: the
// right matrix runs through the feed register and each cell's product, accumulator and done
// registers to the output register, then one result per cycle while rsp_ready holds (16 in
// all); the next item is taken the cycle after the last result transfer. Synchronous active-high
// reset zeroes both matrices and the mode register and empties the pipeline.
`default_nettype none

module matrix4_multiply_engine_top
   import mme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // element loads
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   // product elements
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   // mode register
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   logic                        affine_ff;
   logic                        busy_ff;
   logic                        busy_in;
   logic                        feeding_ff;
   logic                        feeding_in;
   logic [IDX_BITS-1:0]         step_ff;
   logic [IDX_BITS-1:0]         step_in;
   logic [IDX_BITS-1:0]         load_idx_ff;
   logic                        rsp_valid_ff;
   rsp_item_type                rsp_data_ff;

   // Right matrix lives here; each cell holds one row of the left matrix
   logic signed [WORD_BITS-1:0] right_ff [N_ELEM];

   cell_feed_type               feed_ff;
   cell_feed_type               feed_in;
   cell_feed_type               feed_chain [DIM];
   left_write_type              left_wr [DIM];
   logic [DIM-1:0]              cell_done;
   logic signed [ACC_BITS-1:0]  cell_sum [DIM];

   logic                        advance;
   logic                        req_fire;
   logic                        rsp_fire;
   logic                        start_fire;
   logic                        any_done;
   logic signed [ACC_BITS-1:0]  sel_sum;
   logic signed [WORD_BITS-1:0] fin_value;
   logic                        fin_sat;
   logic [K_BITS-1:0]           step_k;
   logic [K_BITS-1:0]           step_col;

   // ---------------------------------------------------------------------
   // Handshakes: the whole cell chain moves only when the output
   // register is free or being emptied this cycle
   // ---------------------------------------------------------------------
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !busy_ff;
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid_ff && rsp_ready;
   assign start_fire = req_fire && req_data.start_product;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------------
   // Feeder: walk the right matrix in column-major order, one element
   // per cycle while the chain advances, into the head of the chain
   // ---------------------------------------------------------------------
   assign step_k   = step_ff[K_BITS-1:0];
   assign step_col = step_ff[IDX_BITS-1:K_BITS];

   always_comb begin
      feed_in       = '0;
      feed_in.valid = feeding_ff;
      feed_in.k     = step_k;
      feed_in.value = right_ff[step_ff];
      // Affine mode: bottom row of the right matrix reads as 0, 0, 0, 1.0,
      // which also turns the fourth term into the translation add
      if (affine_ff && (step_k == K_BITS'(DIM - 1))) begin
         feed_in.value = (step_col == K_BITS'(DIM - 1)) ? UNIT_VALUE : '0;
      end
   end

   always_comb begin
      feeding_in = feeding_ff;
      step_in    = step_ff;
      if (start_fire) begin
         feeding_in = 1'b1;
         step_in    = '0;
      end else if (advance && feeding_ff) begin
         step_in = step_ff + IDX_BITS'(1);
         if (step_ff == IDX_BITS'(N_ELEM - 1)) begin
            feeding_in = 1'b0;
         end
      end
   end

   // Hold busy from the start transfer until the final result transfers
   always_comb begin
      busy_in = busy_ff;
      if (start_fire) begin
         busy_in = 1'b1;
      end else if (rsp_fire && rsp_data_ff.last_of_product) begin
         busy_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   assign feed_chain[0] = feed_ff;

   for (genvar r = 0; r < DIM; r++) begin : g_cell
      always_comb begin
         left_wr[r].en    = req_fire && (req_data.target_matrix == TARGET_LEFT) &&
                            (req_data.element_index[K_BITS-1:0] == K_BITS'(r));
         left_wr[r].k     = req_data.element_index[IDX_BITS-1:K_BITS];
         left_wr[r].value = req_data.element_value;
      end

      if (r < DIM - 1) begin : g_link
         mme_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .unit_row (affine_ff && (r == DIM - 1)),
            .left_wr  (left_wr[r]),
            .feed_in  (feed_chain[r]),
            .feed_out (feed_chain[r+1]),
            .done     (cell_done[r]),
            .sum      (cell_sum[r])
         );
      end else begin : g_tail
         mme_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .unit_row (affine_ff),
            .left_wr  (left_wr[r]),
            .feed_in  (feed_chain[r]),
            .feed_out (),
            .done     (cell_done[r]),
            .sum      (cell_sum[r])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Result select: the chain stagger lets at most one cell finish per
   // cycle, and in column-major order
   // ---------------------------------------------------------------------
   assign any_done = |cell_done;

   always_comb begin
      sel_sum = cell_sum[0];
      for (int i = 1; i < DIM; i++) begin
         if (cell_done[i]) begin
            sel_sum = cell_sum[i];
         end
      end
   end

   mme_round_sat u_round_sat (
      .sum       (sel_sum),
      .value     (fin_value),
      .saturated (fin_sat)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         affine_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         feeding_ff   <= 1'b0;
         step_ff      <= '0;
         feed_ff      <= '0;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N_ELEM; i++) begin
            right_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            affine_ff <= csr_data;
         end
         busy_ff    <= busy_in;
         feeding_ff <= feeding_in;
         step_ff    <= step_in;
         if (req_fire && (req_data.target_matrix == TARGET_RIGHT)) begin
            right_ff[req_data.element_index] <= req_data.element_value;
         end
         if (advance) begin
            feed_ff      <= feed_in;
            rsp_valid_ff <= any_done;
            if (any_done) begin
               load_idx_ff <= load_idx_ff + IDX_BITS'(1);
            end
         end
      end
   end

   // Output payload: load with each finished entry
   always_ff @(posedge clock) begin
      if (advance && any_done) begin
         rsp_data_ff.product_value   <= fin_value;
         rsp_data_ff.product_index   <= load_idx_ff;
         rsp_data_ff.saturated       <= fin_sat;
         rsp_data_ff.last_of_product <= (load_idx_ff == IDX_BITS'(N_ELEM - 1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/mme_cell.sv]
// One multiply-accumulate cell: holds one row of the left matrix.
// Depends on mme_pkg.
`default_nettype none

module mme_cell
   import mme_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       unit_row,
   input  left_write_type             left_wr,
   input  cell_feed_type              feed_in,
   output cell_feed_type              feed_out,
   output logic                       done,
   output logic signed [ACC_BITS-1:0] sum
);

   logic signed [WORD_BITS-1:0] row_ff [DIM];
   logic signed [WORD_BITS-1:0] row_in [DIM];
   logic signed [WORD_BITS-1:0] left_op;
   cell_feed_type               feed_ff;
   logic                        pv_ff;
   logic [K_BITS-1:0]           pk_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic                        done_ff;

   always_comb begin
      row_in = row_ff;
      if (left_wr.en) begin
         row_in[left_wr.k] = left_wr.value;
      end
   end

   // Fixed row of the affine bottom: 0, 0, 0, 1.0
   assign left_op = unit_row ? ((feed_in.k == K_BITS'(DIM - 1)) ? UNIT_VALUE : '0)
                             : row_ff[feed_in.k];

   assign prod_in = PROD_BITS'(left_op) * PROD_BITS'(feed_in.value);

   // Restart on the first term of each dot product
   assign acc_in = (pk_ff == '0) ? ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM; i++) begin
            row_ff[i] <= '0;
         end
         feed_ff <= '0;
         pv_ff   <= 1'b0;
         pk_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (advance) begin
            feed_ff <= feed_in;
            pv_ff   <= feed_in.valid;
            pk_ff   <= feed_in.k;
            done_ff <= pv_ff && (pk_ff == K_BITS'(DIM - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         if (pv_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign feed_out = feed_ff;
   assign done     = done_ff;
   assign sum      = acc_ff;

endmodule

`default_nettype wire

[rtl/mme_round_sat.sv]
// Rounding and saturation of an exact dot-product sum to a word.
// Depends on mme_pkg.
`default_nettype none

module mme_round_sat
   import mme_pkg::*;
(
   input  logic signed [ACC_BITS-1:0]  sum,
   output logic signed [WORD_BITS-1:0] value,
   output logic                        saturated
);

   logic signed [ACC_BITS-1:0] rounded;
   logic                       fits;

   // Nearest, ties toward plus infinity
   assign rounded = (sum + ROUND_HALF) >>> FRAC_BITS;

   assign fits = ~|rounded[ACC_BITS-1:WORD_BITS-1] | &rounded[ACC_BITS-1:WORD_BITS-1];

   always_comb begin
      if (fits) begin
         value = rounded[WORD_BITS-1:0];
      end else if (rounded[ACC_BITS-1]) begin
         value = WORD_MIN;
      end else begin
         value = WORD_MAX;
      end
   end

   assign saturated = ~fits;

endmodule

`default_nettype wire

[rtl/mme_checker.sv]
// Port-level checker for the 4x4 matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix4_multiply_engine_top_defines.svh.
`default_nettype none
`include "matrix4_multiply_engine_top_defines.svh"

module mme_checker
   import mme_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // A stalled result holds
   `MME_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp payload changed while stalled")

   // A start transfer closes the request side
   `MME_ASSERT_IF(a_start_blocks, req_valid && req_ready && req_data.start_product, ##1 !req_ready, "request taken during a product")

   // Results appear only while the request side is closed
   `MME_ASSERT_IF(a_rsp_only_busy, rsp_valid, !req_ready, "result shown while idle")

   // Final result transfer reopens the request side
   `MME_ASSERT_IF(a_last_reopens, rsp_valid && rsp_ready && rsp_data.last_of_product, ##1 req_ready, "not ready after last transfer")

   // Last flag marks the final position
   `MME_ASSERT_IF(a_last_index, rsp_valid, rsp_data.last_of_product == (rsp_data.product_index == 4'd15), "last flag and index disagree")

endmodule

bind matrix4_multiply_engine_top mme_checker u_mme_checker (.*);

`default_nettype wire

[sim/matrix4_multiply_engine_top_tb.sv]
// Self-checking testbench for matrix4_multiply_engine_top: element loads, full and affine
// products, rounding and saturation, checked against an in-bench product predictor.
// Depends on mme_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module matrix4_multiply_engine_top_tb
   import mme_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 1000;
   // Quiet cycles after the last result before the engine counts as idle
   localparam int SETTLE_CYCLES  = 32;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;

   // Shadow copy of the engine state
   logic signed [WORD_BITS-1:0] left_matrix [N_ELEM];
   logic signed [WORD_BITS-1:0] right_matrix[N_ELEM];
   logic                        affine_on;

   // Product elements still owed by the engine, oldest first
   rsp_item_type expected_products[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int fail_count;
   int idle_cycles;

   matrix4_multiply_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Product predictor
   // ------------------------------------------------------------------

   // Compute one product element: exact sum of full-width products, round to
   // nearest (ties up), then clip to the word range.
   function automatic rsp_item_type product_element(input int col, input int row);
      logic signed [79:0] acc;
      logic signed [79:0] lhs;
      logic signed [79:0] rhs;
      logic signed [79:0] rounded;
      logic signed [79:0] hi_lim;
      logic signed [79:0] lo_lim;
      rsp_item_type       elem;
      int                 depth;
      acc     = '0;
      hi_lim  = WORD_MAX;
      lo_lim  = WORD_MIN;
      elem.product_index   = IDX_BITS'(col * DIM + row);
      elem.last_of_product = (col == DIM - 1) && (row == DIM - 1);
      elem.saturated       = 1'b0;
      // Affine bottom row is fixed at 0, 0, 0, 1.0
      if (affine_on && row == DIM - 1) begin
         elem.product_value = (col == DIM - 1) ? UNIT_VALUE : '0;
         return elem;
      end
      depth = affine_on ? DIM - 1 : DIM;
      for (int k = 0; k < depth; k++) begin
         lhs = left_matrix[k * DIM + row];
         rhs = right_matrix[col * DIM + k];
         acc = acc + lhs * rhs;
      end
      // Affine translation column picks up the left translation term
      if (affine_on && col == DIM - 1) begin
         lhs = left_matrix[(DIM - 1) * DIM + row];
         acc = acc + (lhs <<< FRAC_BITS);
      end
      rounded = (acc + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (rounded > hi_lim) begin
         elem.product_value = WORD_MAX;
         elem.saturated     = 1'b1;
      end else if (rounded < lo_lim) begin
         elem.product_value = WORD_MIN;
         elem.saturated     = 1'b1;
      end else begin
         elem.product_value = rounded[WORD_BITS-1:0];
      end
      return elem;
   endfunction

   // Store the element, then queue all 16 product elements if a product starts
   task automatic predict_load(input req_item_type item);
      if (item.target_matrix == TARGET_RIGHT) begin
         right_matrix[item.element_index] = item.element_value;
      end else begin
         left_matrix[item.element_index] = item.element_value;
      end
      if (item.start_product) begin
         for (int col = 0; col < DIM; col++) begin
            for (int row = 0; row < DIM; row++) begin
               expected_products.push_back(product_element(col, row));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one element load. Hold valid and payload until the transfer; idle
   // beforehand at the current sender rate.
   task automatic send_element(input logic target, input int index,
                               input logic signed [WORD_BITS-1:0] value, input logic start);
      req_item_type item;
      item.target_matrix = target;
      item.element_index = IDX_BITS'(index);
      item.element_value = value;
      item.start_product = start;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_load(item);
   endtask

   // Drop valid and wait until every owed product element has arrived and
   // the engine has had time to finish any load in flight.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the mode register; only done with the engine idle
   task automatic write_mode(input logic mode);
      wait_until_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      affine_on = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver back-pressure at the current stall rate
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Result checker: compare each result transfer with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_products.size() == 0) begin
            $error("unexpected product element at index %0d", rsp_data.product_index);
            fail_count++;
         end else begin
            want = expected_products.pop_front();
            if (rsp_data.product_value !== want.product_value) begin
               $error("product_value expected %0d got %0d",
                      want.product_value, rsp_data.product_value);
               fail_count++;
            end
            if (rsp_data.product_index !== want.product_index) begin
               $error("product_index expected %0d got %0d",
                      want.product_index, rsp_data.product_index);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %0d got %0d", want.saturated, rsp_data.saturated);
               fail_count++;
            end
            if (rsp_data.last_of_product !== want.last_of_product) begin
               $error("last_of_product expected %0d got %0d",
                      want.last_of_product, rsp_data.last_of_product);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mix full-range words, small values within +/-4.0, mid-range values and extremes
   function automatic logic signed [WORD_BITS-1:0] random_element_value();
      logic signed [WORD_BITS-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom();
         1: begin
            v = $urandom_range(0, 32'h0008_0000);
            v = v - 32'sh0004_0000;
         end
         2: begin
            v = $urandom_range(0, 32'h0200_0000);
            v = v - 32'sh0100_0000;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = WORD_MAX;
               1:       v = WORD_MIN;
               2:       v = '0;
               3:       v = UNIT_VALUE;
               default: v = -UNIT_VALUE;
            endcase
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Product straight out of reset: both stores cleared, so all zero
   task automatic test_cleared_stores();
      send_element(TARGET_LEFT, 0, '0, 1'b1);
   endtask

   // Rounding ties go toward plus infinity; a load without start emits nothing
   task automatic test_rounding();
      send_element(TARGET_RIGHT, 0, 32'sh0000_8000, 1'b0);
      send_element(TARGET_LEFT, 0, 32'sh0000_0001, 1'b1);
      send_element(TARGET_LEFT, 0, -32'sh0000_0001, 1'b1);
   endtask

   // Clip in both directions, and touch the last index of both stores
   task automatic test_saturation();
      send_element(TARGET_RIGHT, 15, WORD_MIN, 1'b0);
      send_element(TARGET_LEFT, 15, WORD_MAX, 1'b0);
      send_element(TARGET_RIGHT, 0, WORD_MAX, 1'b0);
      send_element(TARGET_LEFT, 0, WORD_MAX, 1'b1);
      send_element(TARGET_LEFT, 0, WORD_MIN, 1'b1);
      send_element(TARGET_RIGHT, 0, WORD_MIN, 1'b1);
   endtask

   // Identity on the left passes the right matrix through
   task automatic test_identity_product();
      send_element(TARGET_LEFT, 0, UNIT_VALUE, 1'b0);
      send_element(TARGET_LEFT, 5, UNIT_VALUE, 1'b0);
      send_element(TARGET_LEFT, 10, UNIT_VALUE, 1'b0);
      send_element(TARGET_LEFT, 15, UNIT_VALUE, 1'b0);
      send_element(TARGET_RIGHT, 6, 32'sh0003_4000, 1'b1);
   endtask

   // Affine: bottom rows of both stores ignored, translation column added
   task automatic test_affine_mode();
      write_mode(1'b1);
      send_element(TARGET_LEFT, 3, WORD_MAX, 1'b0);
      send_element(TARGET_RIGHT, 7, WORD_MIN, 1'b0);
      send_element(TARGET_LEFT, 12, 32'sh7FFF_0000, 1'b0);
      send_element(TARGET_LEFT, 13, -32'sh0002_8000, 1'b0);
      send_element(TARGET_RIGHT, 15, UNIT_VALUE, 1'b1);
      write_mode(1'b0);
   endtask

   // Random phase: mostly short load bursts or whole-matrix loads ending in a
   // product start, the rest lone items as noise
   task automatic run_random_phase(input int send_pct, input int stall_pct,
                                   input int item_budget, input logic mode,
                                   input logic pause_midway);
      int   sent;
      int   burst;
      logic target;
      logic paused;
      sent   = 0;
      paused = 1'b0;
      write_mode(mode);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      while (sent < item_budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               burst = $urandom_range(1, 6);
               for (int i = 0; i < burst; i++) begin
                  send_element(1'($urandom_range(0, 1)), $urandom_range(0, N_ELEM - 1),
                               random_element_value(), i == burst - 1);
               end
               sent += burst;
            end
            5, 6: begin
               target = 1'($urandom_range(0, 1));
               for (int i = 0; i < N_ELEM; i++) begin
                  send_element(target, i, random_element_value(), i == N_ELEM - 1);
               end
               sent += N_ELEM;
            end
            default: begin
               send_element(1'($urandom_range(0, 1)), $urandom_range(0, N_ELEM - 1),
                            random_element_value(), $urandom_range(0, 4) == 0);
               sent++;
            end
         endcase
         // Hold off the sender until the engine has emptied out
         if (pause_midway && !paused && sent >= item_budget / 2) begin
            wait_until_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fail_count    = 0;
      idle_cycles   = 0;
      affine_on     = 1'b0;
      for (int i = 0; i < N_ELEM; i++) begin
         left_matrix[i]  = '0;
         right_matrix[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cleared_stores();
      test_rounding();
      test_saturation();
      test_identity_product();
      test_affine_mode();

      run_random_phase(0, 0, 18, 1'b0, 1'b1);
      run_random_phase(46, 0, 18, 1'b1, 1'b0);
      run_random_phase(0, 46, 18, 1'b0, 1'b0);
      run_random_phase(11, 11, 18, 1'b1, 1'b1);

      wait_until_idle();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[matrix4_multiply_engine_top.f]
+incdir+rtl
rtl/mme_pkg.sv
rtl/mme_cell.sv
rtl/mme_round_sat.sv
rtl/matrix4_multiply_engine_top.sv
rtl/mme_checker.sv
sim/matrix4_multiply_engine_top_tb.sv
